@@ design/three_axis_step_dir_generator_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Three-axis step/dir generator: assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef THREE_AXIS_STEP_DIR_GENERATOR_UNIT_DEFINES_SVH
`define THREE_AXIS_STEP_DIR_GENERATOR_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define TSDG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define TSDG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ design/tsdg_pkg.sv @@
// ----------------------------------------------------------------------------
// Three-axis step/dir generator: package
// Commands, axis codes, register indexes, widths and reset values.
// ----------------------------------------------------------------------------
package tsdg_pkg;

    localparam int NUM_AXES_DEF   = 3;
    localparam int STEP_WIDTH_DEF = 24;
    localparam int POS_WIDTH_DEF  = 32;

    localparam int LANES      = 3;
    localparam int WORD_W     = 16;
    localparam int BIT_W      = 4;
    localparam int STEP_IN_W  = 24;
    localparam int STEP_MAX_W = 32;
    localparam int POS_OUT_W  = 32;
    localparam int POS_EXT_W  = 64;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_GO   = 2'd1,
        CMD_STOP = 2'd2
    } t_cmd;

    localparam logic [1:0] AXIS_X   = 2'd0;
    localparam logic [1:0] AXIS_ALL = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_X_PULSE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Z_DIR   = 3'd5;

    typedef logic [BIT_W-1:0] t_bitpos;

    localparam t_bitpos PULSE_RESET [LANES] = '{4'd0, 4'd3, 4'd8};
    localparam t_bitpos DIR_RESET   [LANES] = '{4'd1, 4'd4, 4'd9};

    typedef struct packed {
        logic tick;
        logic go;
        logic halt;
        logic dir;
    } t_lane_ctl;

endpackage

@@ design/tsdg_lane.sv @@
// ----------------------------------------------------------------------------
// Three-axis step/dir generator: axis lane
// Run flag, direction, remaining step count and position of one axis.
// ----------------------------------------------------------------------------
module tsdg_lane
    import tsdg_pkg::*;
#(
    parameter int STEP_WIDTH = STEP_WIDTH_DEF,
    parameter int POS_WIDTH  = POS_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_lane_ctl             i_ctl,
    input  logic [STEP_WIDTH-1:0] i_steps,
    output logic                  o_running,
    output logic                  o_dir,
    output logic [POS_WIDTH-1:0]  o_pos
);

    logic                  r_running, n_running;
    logic                  r_dir, n_dir;
    logic [STEP_WIDTH-1:0] r_rem, n_rem;
    logic [POS_WIDTH-1:0]  r_pos, n_pos;

    always_comb begin
        n_running = r_running;
        n_dir     = r_dir;
        n_rem     = r_rem;
        n_pos     = r_pos;
        if (i_ctl.go) begin
            n_running = 1'b1;
            n_dir     = i_ctl.dir;
            n_rem     = i_steps;
        end else if (i_ctl.halt) begin
            n_running = 1'b0;
        end else if (i_ctl.tick && r_running) begin
            n_pos = r_dir ? r_pos + POS_WIDTH'(1) : r_pos - POS_WIDTH'(1);
            if (r_rem != '0) begin
                n_rem = r_rem - STEP_WIDTH'(1);
                if (r_rem == STEP_WIDTH'(1)) begin
                    n_running = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_dir     <= 1'b0;
            r_rem     <= '0;
            r_pos     <= '0;
        end else begin
            r_running <= n_running;
            r_dir     <= n_dir;
            r_rem     <= n_rem;
            r_pos     <= n_pos;
        end
    end

    assign o_running = r_running;
    assign o_dir     = r_dir;
    assign o_pos     = r_pos;

endmodule

@@ design/three_axis_step_dir_generator_unit.sv @@
// ----------------------------------------------------------------------------
// Three-axis step/dir generator
// Drives pulse and direction bits of three stepper axes in one 16-bit word.
//
//   channel  dir  handshake                 payload
//   cfg      in   i_cfg_we                  i_cfg_addr, i_cfg_wdata
//   in       in   i_in_valid / o_in_ready   command, axis, direction, steps
//   out      out  o_out_valid / i_out_ready word, running, stopped, positions
//
// One beat per cycle sustained while the output is not stalled; each input
// beat passes the input register, then the axis state and result registers.
// The axis state registers double as the result register, so they advance
// only when the result slot is free or being taken.
// Synchronous active-low reset clears all axis state and restores bit maps.
// An output stall holds the result and fills the input register, then
// drops o_in_ready.
// ----------------------------------------------------------------------------
`include "three_axis_step_dir_generator_unit_defines.svh"

module three_axis_step_dir_generator_unit
    import tsdg_pkg::*;
#(
    parameter int NUM_AXES   = NUM_AXES_DEF,
    parameter int STEP_WIDTH = STEP_WIDTH_DEF,
    parameter int POS_WIDTH  = POS_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [BIT_W-1:0]      i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_command,
    input  logic [1:0]            i_axis_select,
    input  logic                  i_direction,
    input  logic [STEP_IN_W-1:0]  i_step_count,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [WORD_W-1:0]     o_out_word,
    output logic [LANES-1:0]      o_axes_running,
    output logic                  o_all_stopped,
    output logic signed [POS_OUT_W-1:0] o_x_position,
    output logic signed [POS_OUT_W-1:0] o_y_position,
    output logic signed [POS_OUT_W-1:0] o_z_position
);

    t_bitpos r_pulse_bit [LANES];
    t_bitpos r_dir_bit   [LANES];

    logic                  r_in_valid;
    t_cmd                  r_cmd;
    logic [1:0]            r_sel;
    logic                  r_dir;
    logic [STEP_WIDTH-1:0] r_steps;
    logic [STEP_MAX_W-1:0] steps_wide;

    logic                  r_out_valid;
    logic                  out_free;
    logic                  fire;

    logic [WORD_W-1:0]     r_word, n_word;
    t_lane_ctl             lane_ctl [LANES];
    logic [LANES-1:0]      running;
    logic [LANES-1:0]      dir_flag;
    logic [POS_WIDTH-1:0]  pos     [LANES];
    logic [POS_EXT_W-1:0]  pos_ext [LANES];

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_bit <= PULSE_RESET;
            r_dir_bit   <= DIR_RESET;
        end else if (i_cfg_we && i_cfg_addr <= REG_Z_DIR
                     && int'(i_cfg_addr[CFG_IDX_W-1:1]) < NUM_AXES) begin
            if (i_cfg_addr[0] == REG_X_PULSE[0]) begin
                r_pulse_bit[i_cfg_addr[CFG_IDX_W-1:1]] <= i_cfg_wdata;
            end else begin
                r_dir_bit[i_cfg_addr[CFG_IDX_W-1:1]] <= i_cfg_wdata;
            end
        end
    end

    // input register
    assign out_free   = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;
    assign steps_wide = STEP_MAX_W'(i_step_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_cmd   <= t_cmd'(i_command);
            r_sel   <= i_axis_select;
            r_dir   <= i_direction;
            r_steps <= steps_wide[STEP_WIDTH-1:0];
        end
    end

    // command decode
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            lane_ctl[i] = '0;
            lane_ctl[i].dir = r_dir;
            if (fire) begin
                unique case (r_cmd)
                    CMD_TICK: lane_ctl[i].tick = 1'b1;
                    CMD_GO:   lane_ctl[i].go   = (int'(r_sel) == i) && (i < NUM_AXES);
                    CMD_STOP: lane_ctl[i].halt = (r_sel == AXIS_ALL) || (int'(r_sel) == i);
                    default:  lane_ctl[i] = lane_ctl[i];
                endcase
            end
        end
    end

    // axis lanes
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        tsdg_lane #(
            .STEP_WIDTH (STEP_WIDTH),
            .POS_WIDTH  (POS_WIDTH)
        ) u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (lane_ctl[g]),
            .i_steps   (r_steps),
            .o_running (running[g]),
            .o_dir     (dir_flag[g]),
            .o_pos     (pos[g])
        );
        assign pos_ext[g] = POS_EXT_W'(signed'(pos[g]));
    end

    // output word, axes applied in order
    always_comb begin
        n_word = r_word;
        if (fire && r_cmd == CMD_TICK) begin
            for (int i = 0; i < LANES; i++) begin
                if (running[i]) begin
                    n_word[r_pulse_bit[i]] = !n_word[r_pulse_bit[i]];
                    n_word[r_dir_bit[i]]   = dir_flag[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_word <= n_word;
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_word     = r_word;
    assign o_axes_running = running;
    assign o_all_stopped  = (running == '0);
    assign o_x_position   = pos_ext[0][POS_OUT_W-1:0];
    assign o_y_position   = pos_ext[1][POS_OUT_W-1:0];
    assign o_z_position   = pos_ext[2][POS_OUT_W-1:0];

    `TSDG_ASSERT_NOW(a_no_overwrite, o_out_valid && !i_out_ready, !fire, "result overwritten while stalled")
    `TSDG_ASSERT_NEXT(a_go_x_runs, fire && r_cmd == CMD_GO && r_sel == AXIS_X, o_axes_running[0], "go on X did not start it")
    `TSDG_ASSERT_NEXT(a_stop_all, fire && r_cmd == CMD_STOP && r_sel == AXIS_ALL, o_all_stopped, "stop all left an axis running")
    `TSDG_ASSERT_NEXT(a_hold_state, !fire, $stable(o_out_word) && $stable(o_axes_running), "state moved without a beat")

endmodule
